// ----- rtl/core/bpt_pkg.sv -----
// shared types, codes and constants of the breakpoint table
package bpt_pkg;

  localparam int ADDR_W      = 48;
  localparam int SERIAL_W    = 16;
  localparam int FUNC_W      = 3;
  localparam int INDEX_W     = 6;
  localparam int TOTAL_W     = 7;
  localparam int DEPTH_DEF   = 16;

  // command codes
  localparam logic [FUNC_W-1:0] FN_CLEAR   = 3'd0;
  localparam logic [FUNC_W-1:0] FN_SET     = 3'd1;
  localparam logic [FUNC_W-1:0] FN_REMOVE  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_ENABLE  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_DISABLE = 3'd4;
  localparam logic [FUNC_W-1:0] FN_READ    = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_RANGE     = 2'd3;

  // patch actions
  localparam logic [1:0] ACT_NONE    = 2'd0;
  localparam logic [1:0] ACT_PLANT   = 2'd1;
  localparam logic [1:0] ACT_RESTORE = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [ADDR_W-1:0]  target_addr;
    logic [INDEX_W-1:0] entry_index;
  } bpt_cmd_t;

  typedef struct packed {
    logic [1:0]          op_status;
    logic [1:0]          patch_action;
    logic [ADDR_W-1:0]   patch_addr;
    logic [ADDR_W-1:0]   entry_addr;
    logic [SERIAL_W-1:0] entry_serial;
    logic                entry_enabled;
    logic [TOTAL_W-1:0]  entry_total;
  } bpt_rsp_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   addr;
    logic [SERIAL_W-1:0] serial;
    logic                enabled;
  } bpt_entry_t;

endpackage

// ----- rtl/core/bpt_ram.sv -----
// entry storage: one write port, one read port, registered read data
module bpt_ram #(
  parameter int DEPTH = bpt_pkg::DEPTH_DEF,
  parameter int IDX_W = 4
) (
  input  logic               clk,
  input  logic               we,
  input  logic [IDX_W-1:0]   waddr,
  input  bpt_pkg::bpt_entry_t wdata,
  input  logic [IDX_W-1:0]   raddr,
  output bpt_pkg::bpt_entry_t rdata
);

  bpt_pkg::bpt_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/breakpoint_table.sv -----
// breakpoint table top level: command sequencer around the entry memory
// sequence: clear and unused codes go straight to the result, read entry goes
//   through the memory read state, set/enable/disable/remove scan the list to a
//   match or its end, and remove then moves the tail down over the matched entry
// throughput: one transaction at a time, bounded by the memory's single read
//   port walking the entries; a new command is taken once the result is queued
// reset: sequencer, entry count and serial counter cleared; entries not cleared
module breakpoint_table #(
  parameter int TABLE_DEPTH = bpt_pkg::DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  bpt_pkg::bpt_cmd_t cmd,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output bpt_pkg::bpt_rsp_t rsp
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_READ, S_SHIFT, S_DONE} state_t;

  state_t state;

  // command being worked on
  logic [bpt_pkg::FUNC_W-1:0]   func_q;
  logic [bpt_pkg::ADDR_W-1:0]   tgt;

  // table bookkeeping
  logic [CNT_W-1:0]             used;
  logic [bpt_pkg::SERIAL_W-1:0] serial;
  logic [bpt_pkg::SERIAL_W-1:0] serial_next;

  // scan pointer: entry whose read is issued this cycle
  logic [CNT_W-1:0]             ptr;
  // compare stage: entry whose read data is on the memory output
  logic                         cmp_valid;
  logic [CNT_W-1:0]             cmp_idx;
  // tail move: pending write of the entry read last cycle
  logic                         shift_pend;
  logic [IDX_W-1:0]             shift_wa;

  // result under construction
  logic [1:0]                   res_status;
  logic [1:0]                   res_action;
  bpt_pkg::bpt_entry_t          res_ent;

  // memory ports
  logic                         mem_we;
  logic [IDX_W-1:0]             mem_wa;
  bpt_pkg::bpt_entry_t          mem_wd;
  logic [IDX_W-1:0]             mem_ra;
  bpt_pkg::bpt_entry_t          mem_rd;

  logic                         hit;
  logic                         scan_end;
  logic                         cmd_fire;
  logic                         rsp_load;
  logic                         read_ok;

  assign cmd_ready   = (state == S_IDLE) && !rst;
  assign cmd_fire    = cmd_valid && cmd_ready;
  assign serial_next = serial + 1'b1;

  // match on the entry now read out; end of list once every held entry is issued
  assign hit      = cmp_valid && (mem_rd.addr == tgt);
  assign scan_end = (ptr == used);
  assign read_ok  = (bpt_pkg::TOTAL_W'(cmd.entry_index) < bpt_pkg::TOTAL_W'(used));
  assign rsp_load = (state == S_DONE) && (!rsp_valid || rsp_ready);

  bpt_ram #(
    .DEPTH (TABLE_DEPTH),
    .IDX_W (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_wa),
    .wdata (mem_wd),
    .raddr (mem_ra),
    .rdata (mem_rd)
  );

  // memory port steering
  always_comb begin
    mem_we = 1'b0;
    mem_wa = cmp_idx[IDX_W-1:0];
    mem_wd = mem_rd;
    mem_ra = ptr[IDX_W-1:0];
    unique case (state)
      S_IDLE: begin
        // entry read goes out together with the command
        mem_ra = cmd.entry_index[IDX_W-1:0];
      end
      S_SCAN: begin
        if (hit) begin
          unique case (func_q)
            bpt_pkg::FN_SET: begin
              mem_we         = 1'b1;
              mem_wd.enabled = 1'b1;
            end
            bpt_pkg::FN_ENABLE: begin
              mem_we         = !mem_rd.enabled;
              mem_wd.enabled = 1'b1;
            end
            bpt_pkg::FN_DISABLE: begin
              mem_we         = mem_rd.enabled;
              mem_wd.enabled = 1'b0;
            end
            default: begin
              mem_we = 1'b0;
            end
          endcase
        end else if (scan_end && (func_q == bpt_pkg::FN_SET) && (used != FULL_CNT)) begin
          // append a new entry at the end of the list
          mem_we         = 1'b1;
          mem_wa         = used[IDX_W-1:0];
          mem_wd.addr    = tgt;
          mem_wd.serial  = serial_next;
          mem_wd.enabled = 1'b1;
        end
      end
      S_SHIFT: begin
        // write back the entry read last cycle one place lower
        mem_we = shift_pend;
        mem_wa = shift_wa;
        mem_wd = mem_rd;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // sequencer, bookkeeping and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      used       <= '0;
      serial     <= '0;
      cmp_valid  <= 1'b0;
      shift_pend <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (cmd_fire) begin
            func_q     <= cmd.func;
            tgt        <= cmd.target_addr;
            ptr        <= '0;
            cmp_valid  <= 1'b0;
            res_status <= bpt_pkg::ST_OK;
            res_action <= bpt_pkg::ACT_NONE;
            res_ent    <= '0;
            unique case (cmd.func)
              bpt_pkg::FN_CLEAR: begin
                used   <= '0;
                serial <= '0;
                state  <= S_DONE;
              end
              bpt_pkg::FN_SET, bpt_pkg::FN_REMOVE,
              bpt_pkg::FN_ENABLE, bpt_pkg::FN_DISABLE: begin
                state <= S_SCAN;
              end
              bpt_pkg::FN_READ: begin
                if (read_ok) begin
                  state <= S_READ;
                end else begin
                  res_status <= bpt_pkg::ST_RANGE;
                  state      <= S_DONE;
                end
              end
              default: begin
                // unused codes leave the table alone
                state <= S_DONE;
              end
            endcase
          end
        end

        S_READ: begin
          res_ent <= mem_rd;
          state   <= S_DONE;
        end

        S_SCAN: begin
          if (hit) begin
            cmp_valid <= 1'b0;
            state     <= S_DONE;
            unique case (func_q)
              bpt_pkg::FN_SET: begin
                res_action <= bpt_pkg::ACT_PLANT;
              end
              bpt_pkg::FN_ENABLE: begin
                if (!mem_rd.enabled) begin
                  res_action <= bpt_pkg::ACT_PLANT;
                end
              end
              bpt_pkg::FN_DISABLE: begin
                if (mem_rd.enabled) begin
                  res_action <= bpt_pkg::ACT_RESTORE;
                end
              end
              default: begin
                // remove: move the tail down over the matched entry
                res_action <= bpt_pkg::ACT_RESTORE;
                ptr        <= cmp_idx + 1'b1;
                shift_pend <= 1'b0;
                state      <= S_SHIFT;
              end
            endcase
          end else if (scan_end) begin
            cmp_valid <= 1'b0;
            state     <= S_DONE;
            if (func_q == bpt_pkg::FN_SET) begin
              if (used == FULL_CNT) begin
                res_status <= bpt_pkg::ST_FULL;
              end else begin
                serial     <= serial_next;
                used       <= used + 1'b1;
                res_action <= bpt_pkg::ACT_PLANT;
              end
            end else begin
              res_status <= bpt_pkg::ST_NOT_FOUND;
            end
          end else begin
            cmp_valid <= 1'b1;
            cmp_idx   <= ptr;
            ptr       <= ptr + 1'b1;
          end
        end

        S_SHIFT: begin
          if (ptr != used) begin
            shift_pend <= 1'b1;
            shift_wa   <= IDX_W'(ptr - 1'b1);
            ptr        <= ptr + 1'b1;
          end else begin
            // last pending write lands this cycle
            shift_pend <= 1'b0;
            used       <= used - 1'b1;
            state      <= S_DONE;
          end
        end

        S_DONE: begin
          if (rsp_load) begin
            rsp.op_status     <= res_status;
            rsp.patch_action  <= res_action;
            rsp.patch_addr    <= (res_action != bpt_pkg::ACT_NONE) ? tgt : '0;
            rsp.entry_addr    <= res_ent.addr;
            rsp.entry_serial  <= res_ent.serial;
            rsp.entry_enabled <= res_ent.enabled;
            rsp.entry_total   <= bpt_pkg::TOTAL_W'(used);
            state             <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/bpt_checker.sv -----
// port-level checks of the breakpoint table and their bind
module bpt_checker #(
  parameter int TABLE_DEPTH = bpt_pkg::DEPTH_DEF
) (
  input logic              clk,
  input logic              rst,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input bpt_pkg::bpt_rsp_t rsp
);

  // a held result stays put until taken
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  // count never exceeds capacity
  a_total_cap: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.entry_total <= bpt_pkg::TOTAL_W'(TABLE_DEPTH))
    else $error("entry total above capacity");

  // a patch only comes with ok status, and no patch means no patch address
  a_patch_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.patch_action != bpt_pkg::ACT_NONE) |-> rsp.op_status == bpt_pkg::ST_OK)
    else $error("patch reported with failing status");

  a_patch_addr: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.patch_action == bpt_pkg::ACT_NONE) |-> rsp.patch_addr == '0)
    else $error("patch address without patch");

  // out-of-range read returns empty entry fields
  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.op_status == bpt_pkg::ST_RANGE)
      |-> rsp.entry_addr == '0 && rsp.entry_serial == '0 && !rsp.entry_enabled)
    else $error("entry fields set on out-of-range read");

endmodule

bind breakpoint_table bpt_checker #(
  .TABLE_DEPTH (TABLE_DEPTH)
) u_bpt_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

// ----- test/tb_breakpoint_table.sv -----
// testbench for the breakpoint table: random and directed commands checked against a predictor
`timescale 1ns / 1ps

module tb_breakpoint_table;

  localparam int DEPTH = 16;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 40;
  localparam logic [bpt_pkg::ADDR_W-1:0] ADDR_ONES = '1;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cmd_valid = 1'b0;
  logic              cmd_ready;
  bpt_pkg::bpt_cmd_t cmd = '0;
  logic              rsp_valid;
  logic              rsp_ready = 1'b0;
  bpt_pkg::bpt_rsp_t rsp;

  breakpoint_table #(
    .TABLE_DEPTH(DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd(cmd),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  // commands waiting to be offered, and responses the table still owes us
  bpt_pkg::bpt_cmd_t          pending_cmds[$];
  bpt_pkg::bpt_rsp_t          awaited_rsp[$];
  logic [bpt_pkg::ADDR_W-1:0] addr_pool[$];

  // shadow copy of the breakpoint list
  bpt_pkg::bpt_entry_t          bp_slots[DEPTH];
  int                           bp_used = 0;
  logic [bpt_pkg::SERIAL_W-1:0] bp_serial = '0;

  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   hold_request = 0;
  int   hold_left = 0;
  int   mismatches = 0;
  int   cycle_count = 0;
  logic cmd_fired = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  // watchdog on the whole run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // apply one command to the shadow list and return the response it should give
  function automatic bpt_pkg::bpt_rsp_t step_table(input bpt_pkg::bpt_cmd_t c);
    bpt_pkg::bpt_rsp_t r;
    int                hit;
    r = '0;
    r.op_status = bpt_pkg::ST_OK;
    r.patch_action = bpt_pkg::ACT_NONE;
    hit = -1;
    // first match wins, head entry included
    for (int i = 0; i < bp_used; i++) begin
      if (hit < 0 && bp_slots[i].addr == c.target_addr) hit = i;
    end
    case (c.func)
      bpt_pkg::FN_CLEAR: begin
        bp_used = 0;
        bp_serial = '0;
      end
      bpt_pkg::FN_SET: begin
        if (hit >= 0) begin
          // already held: re-arm it, no new serial
          bp_slots[hit].enabled = 1'b1;
          r.patch_action = bpt_pkg::ACT_PLANT;
        end else if (bp_used >= DEPTH) begin
          r.op_status = bpt_pkg::ST_FULL;
        end else begin
          bp_serial = bp_serial + 1'b1;
          bp_slots[bp_used].addr = c.target_addr;
          bp_slots[bp_used].serial = bp_serial;
          bp_slots[bp_used].enabled = 1'b1;
          bp_used++;
          r.patch_action = bpt_pkg::ACT_PLANT;
        end
      end
      bpt_pkg::FN_REMOVE: begin
        if (hit < 0) begin
          r.op_status = bpt_pkg::ST_NOT_FOUND;
        end else begin
          // close the gap, order is kept
          for (int i = hit; i + 1 < bp_used; i++) bp_slots[i] = bp_slots[i + 1];
          bp_used--;
          r.patch_action = bpt_pkg::ACT_RESTORE;
        end
      end
      bpt_pkg::FN_ENABLE: begin
        if (hit < 0) begin
          r.op_status = bpt_pkg::ST_NOT_FOUND;
        end else if (!bp_slots[hit].enabled) begin
          bp_slots[hit].enabled = 1'b1;
          r.patch_action = bpt_pkg::ACT_PLANT;
        end
      end
      bpt_pkg::FN_DISABLE: begin
        if (hit < 0) begin
          r.op_status = bpt_pkg::ST_NOT_FOUND;
        end else if (bp_slots[hit].enabled) begin
          bp_slots[hit].enabled = 1'b0;
          r.patch_action = bpt_pkg::ACT_RESTORE;
        end
      end
      bpt_pkg::FN_READ: begin
        if (c.entry_index < bp_used) begin
          r.entry_addr = bp_slots[c.entry_index].addr;
          r.entry_serial = bp_slots[c.entry_index].serial;
          r.entry_enabled = bp_slots[c.entry_index].enabled;
        end else begin
          r.op_status = bpt_pkg::ST_RANGE;
        end
      end
      default: begin
        // unused codes leave everything alone
      end
    endcase
    if (r.patch_action != bpt_pkg::ACT_NONE) r.patch_addr = c.target_addr;
    r.entry_total = 7'(bp_used);
    return r;
  endfunction

  task automatic check_response(input bpt_pkg::bpt_rsp_t want, input bpt_pkg::bpt_rsp_t got);
    if (got.op_status !== want.op_status) begin
      $error("op_status: expected %0d, got %0d", want.op_status, got.op_status);
      mismatches++;
    end
    if (got.patch_action !== want.patch_action) begin
      $error("patch_action: expected %0d, got %0d", want.patch_action, got.patch_action);
      mismatches++;
    end
    if (got.patch_addr !== want.patch_addr) begin
      $error("patch_addr: expected %h, got %h", want.patch_addr, got.patch_addr);
      mismatches++;
    end
    if (got.entry_addr !== want.entry_addr) begin
      $error("entry_addr: expected %h, got %h", want.entry_addr, got.entry_addr);
      mismatches++;
    end
    if (got.entry_serial !== want.entry_serial) begin
      $error("entry_serial: expected %0d, got %0d", want.entry_serial, got.entry_serial);
      mismatches++;
    end
    if (got.entry_enabled !== want.entry_enabled) begin
      $error("entry_enabled: expected %0d, got %0d", want.entry_enabled, got.entry_enabled);
      mismatches++;
    end
    if (got.entry_total !== want.entry_total) begin
      $error("entry_total: expected %0d, got %0d", want.entry_total, got.entry_total);
      mismatches++;
    end
  endtask

  // monitor: sample both handshakes at the rising edge
  always @(posedge clk) begin
    cmd_fired = 1'b0;
    if (!rst) begin
      if (cmd_valid && cmd_ready) begin
        cmd_fired = 1'b1;
        awaited_rsp.push_back(step_table(cmd));
      end
      if (rsp_valid && rsp_ready) begin
        if (awaited_rsp.size() == 0) begin
          $error("response transaction with nothing outstanding");
          mismatches++;
        end else begin
          check_response(awaited_rsp.pop_front(), rsp);
        end
      end
    end
  end

  // command driver: offer the next pending command once the slot is free
  always @(negedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (!cmd_valid || cmd_fired) begin
      if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        cmd <= pending_cmds.pop_front();
        cmd_valid <= 1'b1;
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  // response side: random back-pressure plus an occasional long hold-off
  always @(negedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rsp_ready <= 1'b0;
    end else if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // mostly random 48-bit address, sometimes an extreme
  function automatic logic [bpt_pkg::ADDR_W-1:0] rand_addr();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 19))
      0: return '0;
      1: return ADDR_ONES;
      default: return r[bpt_pkg::ADDR_W-1:0];
    endcase
  endfunction

  function automatic bpt_pkg::bpt_cmd_t make_cmd(input logic [bpt_pkg::FUNC_W-1:0] fn,
                                                 input logic [bpt_pkg::ADDR_W-1:0] addr,
                                                 input int idx);
    bpt_pkg::bpt_cmd_t c;
    c.func = fn;
    c.target_addr = addr;
    c.entry_index = bpt_pkg::INDEX_W'(idx);
    return c;
  endfunction

  // fresh addresses join the pool so later commands can hit them
  function automatic logic [bpt_pkg::ADDR_W-1:0] fresh_addr();
    logic [bpt_pkg::ADDR_W-1:0] a;
    a = rand_addr();
    addr_pool.push_back(a);
    if (addr_pool.size() > 32) void'(addr_pool.pop_front());
    return a;
  endfunction

  function automatic logic [bpt_pkg::ADDR_W-1:0] pool_addr();
    if ($urandom_range(0, 3) == 0) return fresh_addr();
    return addr_pool[$urandom_range(0, addr_pool.size() - 1)];
  endfunction

  function automatic bpt_pkg::bpt_cmd_t random_cmd();
    int pick;
    int idx;
    pick = $urandom_range(0, 99);
    idx = $urandom_range(0, 63);
    if (pick < 2) return make_cmd(bpt_pkg::FN_CLEAR, rand_addr(), idx);
    if (pick < 34) return make_cmd(bpt_pkg::FN_SET, pool_addr(), idx);
    if (pick < 50) return make_cmd(bpt_pkg::FN_REMOVE, pool_addr(), idx);
    if (pick < 62) return make_cmd(bpt_pkg::FN_ENABLE, pool_addr(), idx);
    if (pick < 74) return make_cmd(bpt_pkg::FN_DISABLE, pool_addr(), idx);
    if (pick < 96) begin
      // reads mostly around the live part of the list
      if ($urandom_range(0, 9) < 7) idx = $urandom_range(0, DEPTH + 1);
      return make_cmd(bpt_pkg::FN_READ, rand_addr(), idx);
    end
    return make_cmd($urandom_range(0, 1) ? 3'd6 : 3'd7, rand_addr(), idx);
  endfunction

  task automatic queue_random(input int n);
    int k;
    k = 0;
    while (k < n) begin
      if ($urandom_range(0, 99) == 0) begin
        // burst of new sets that runs the table into full, then read its edge
        for (int j = 0; j < DEPTH + 2; j++) begin
          pending_cmds.push_back(make_cmd(bpt_pkg::FN_SET, fresh_addr(), $urandom_range(0, 63)));
        end
        pending_cmds.push_back(make_cmd(bpt_pkg::FN_READ, rand_addr(), DEPTH - 1));
        pending_cmds.push_back(make_cmd(bpt_pkg::FN_READ, rand_addr(), DEPTH));
        k += DEPTH + 4;
      end else begin
        pending_cmds.push_back(random_cmd());
        k++;
      end
    end
  endtask

  // wait until every queued command has been sent and every transaction has come back
  task automatic wait_drained();
    while (pending_cmds.size() != 0 || cmd_valid || awaited_rsp.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic queue_directed();
    logic [bpt_pkg::ADDR_W-1:0] miss;
    miss = rand_addr() | 48'h1;
    pending_cmds.push_back(make_cmd(bpt_pkg::FN_READ, miss, 0));       // empty list read
    pending_cmds.push_back(make_cmd(bpt_pkg::FN_REMOVE, miss, 0));     // not found
    pending_cmds.push_back(make_cmd(bpt_pkg::FN_DISABLE, miss, 0));    // not found
    pending_cmds.push_back(make_cmd(bpt_pkg::FN_SET, '0, 63));
    pending_cmds.push_back(make_cmd(bpt_pkg::FN_SET, ADDR_ONES, 0));
    pending_cmds.push_back(make_cmd(bpt_pkg::FN_SET, '0, 0));          // match on head entry
    pending_cmds.push_back(make_cmd(bpt_pkg::FN_DISABLE, ADDR_ONES, 0));
    pending_cmds.push_back(make_cmd(bpt_pkg::FN_DISABLE, ADDR_ONES, 0)); // already off
    pending_cmds.push_back(make_cmd(bpt_pkg::FN_SET, ADDR_ONES, 0));   // re-arm a disabled one
    pending_cmds.push_back(make_cmd(bpt_pkg::FN_DISABLE, ADDR_ONES, 0));
    pending_cmds.push_back(make_cmd(bpt_pkg::FN_ENABLE, ADDR_ONES, 0));
    pending_cmds.push_back(make_cmd(bpt_pkg::FN_ENABLE, ADDR_ONES, 0)); // already on
    pending_cmds.push_back(make_cmd(bpt_pkg::FN_READ, miss, 1));
    pending_cmds.push_back(make_cmd(bpt_pkg::FN_READ, miss, 63));      // past the end
    pending_cmds.push_back(make_cmd(3'd6, ADDR_ONES, 63));
    pending_cmds.push_back(make_cmd(3'd7, miss, 42));
    pending_cmds.push_back(make_cmd(bpt_pkg::FN_REMOVE, '0, 0));       // head removal, tail shifts
    pending_cmds.push_back(make_cmd(bpt_pkg::FN_READ, '0, 0));
    pending_cmds.push_back(make_cmd(bpt_pkg::FN_CLEAR, ADDR_ONES, 63));
    pending_cmds.push_back(make_cmd(bpt_pkg::FN_READ, miss, 0));
    pending_cmds.push_back(make_cmd(bpt_pkg::FN_SET, miss, 21));       // serial restarts
    pending_cmds.push_back(make_cmd(bpt_pkg::FN_READ, miss, 0));
    addr_pool.push_back(miss);
  endtask

  initial begin
    int start_left;
    addr_pool.push_back('0);
    addr_pool.push_back(ADDR_ONES);
    for (int i = 0; i < 18; i++) addr_pool.push_back(rand_addr());

    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // phase one: sender mostly busy, receiver mostly stalled
    send_idle_pct = 19;
    recv_idle_pct = 86;
    queue_directed();
    queue_random(340);
    wait_drained();

    // phase two: the other way round
    send_idle_pct = 86;
    recv_idle_pct = 19;
    queue_random(360);
    wait_drained();

    // phase three: full rate, with one long receiver hold-off to back the block up
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(380);
    start_left = pending_cmds.size();
    while (pending_cmds.size() > start_left - 10) @(negedge clk);
    hold_request = 400;
    wait_drained();

    // let any stray response show up
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/bpt_pkg.sv
rtl/core/bpt_ram.sv
rtl/core/breakpoint_table.sv
rtl/core/bpt_checker.sv
test/tb_breakpoint_table.sv
